// ===== rtl/core/gtb_pkg.sv =====
// Shared widths, constants, types and tanh table generator for the GELU backward block.
`timescale 1ns / 1ps

package gtb_pkg;

  localparam int NSTG = 13;

  localparam int QB = 24;
  localparam int Q_ONE = 1 << QB;
  localparam int ROUND_Q = 1 << (QB - 1);
  localparam int X_LIM = 4 << QB;

  localparam int K_SQRT2PI = 13386282;
  localparam int K_HALF_SQRT2PI = 6693141;
  localparam int K_A = 750193;
  localparam int K_B = 2250580;

  localparam int SEG_FRAC = 26;

  localparam int GW = 16;
  localparam int XW = 28;
  localparam int X2W = 30;
  localparam int X3W = 32;
  localparam int POLYW = 27;
  localparam int SUMW = 29;
  localparam int UW = 29;
  localparam int TW = 25;
  localparam int TSW = 26;
  localparam int CDFW = 26;
  localparam int SECHW = 26;
  localparam int P1W = 27;
  localparam int P2W = 26;
  localparam int DW = 29;
  localparam int RESW = 21;

  typedef struct packed {
    logic st_a;
    logic st_b;
    logic st_c;
  } gtb_tanh_en_t;

  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] exp_neg_q31(input logic [63:0] z);
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] term;
    logic [63:0] e;
    pos = 64'h8000_0000;
    neg = '0;
    term = 64'h8000_0000;
    for (int n = 1; n <= 20; n++) begin
      term = udiv64((term * z + 64'h4000_0000) >> 31, 64'(n));
      if (n[0]) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    e = pos - neg;
    for (int s = 0; s < 4; s++) begin
      e = (e * e + 64'h4000_0000) >> 31;
    end
    return e;
  endfunction

  function automatic logic [TW-1:0] tanh_entry(input int unsigned k, input int unsigned d);
    logic [63:0] z;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    z = udiv64((64'(k) << 30) + (64'(d) >> 1), 64'(d));
    e = exp_neg_q31(z);
    num = (64'h8000_0000 - e) << QB;
    den = 64'h8000_0000 + e;
    return TW'(udiv64(num + (den >> 1), den));
  endfunction

endpackage

// ===== rtl/core/gtb_tanh.sv =====
// Three-stage piecewise-linear tanh unit with a table ROM built at elaboration.
`timescale 1ns / 1ps

module gtb_tanh import gtb_pkg::*; #(
  parameter int TANH_TABLE_DEPTH = 256
) (
  input  logic                  clk,
  input  gtb_tanh_en_t          en,
  input  logic signed [UW-1:0]  u,
  output logic signed [TSW-1:0] t_r
);

  localparam int AW = $clog2(TANH_TABLE_DEPTH + 1);
  localparam int PW = SEG_FRAC + AW;
  localparam int MW = TW + SEG_FRAC;

  logic [TW-1:0] rom [0:TANH_TABLE_DEPTH];

  for (genvar k = 0; k <= TANH_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [TW-1:0] ENTRY = tanh_entry(k, TANH_TABLE_DEPTH);
    assign rom[k] = ENTRY;
  end

  logic [UW-2:0]       mag_in;
  logic [PW-1:0]       pos;
  logic [AW-1:0]       idx_nxt;
  logic [AW-1:0]       idx_r;
  logic [AW-1:0]       idx_hi;
  logic [SEG_FRAC-1:0] frac_a_r;
  logic [SEG_FRAC-1:0] frac_b_r;
  logic                sat_nxt;
  logic                sat_a_r;
  logic                sat_b_r;
  logic                neg_a_r;
  logic                neg_b_r;
  logic [TW-1:0]       lo_r;
  logic [TW-1:0]       hi_r;
  logic [TW-1:0]       diff;
  logic [MW-1:0]       prod;
  logic [MW-1:0]       step;
  logic [TW-1:0]       mag;
  logic signed [TSW-1:0] t_nxt;

  assign mag_in  = u[UW-1] ? (UW-1)'(-u) : (UW-1)'(u);
  assign sat_nxt = |mag_in[UW-2:SEG_FRAC];
  assign pos     = PW'(mag_in[SEG_FRAC-1:0]) * PW'(TANH_TABLE_DEPTH);
  assign idx_nxt = pos[SEG_FRAC +: AW];
  assign idx_hi  = idx_r + AW'(1);

  always_ff @(posedge clk) begin
    if (en.st_a) begin
      idx_r    <= idx_nxt;
      frac_a_r <= pos[SEG_FRAC-1:0];
      sat_a_r  <= sat_nxt;
      neg_a_r  <= u[UW-1];
    end
    if (en.st_b) begin
      lo_r     <= rom[idx_r];
      hi_r     <= rom[idx_hi];
      frac_b_r <= frac_a_r;
      sat_b_r  <= sat_a_r;
      neg_b_r  <= neg_a_r;
    end
    if (en.st_c) begin
      t_r <= t_nxt;
    end
  end

  always_comb begin
    diff  = (hi_r > lo_r) ? (hi_r - lo_r) : '0;
    prod  = MW'(diff) * MW'(frac_b_r);
    step  = (prod + (MW'(1) << (SEG_FRAC - 1))) >> SEG_FRAC;
    mag   = sat_b_r ? TW'(Q_ONE) : (lo_r + TW'(step));
    t_nxt = neg_b_r ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

endmodule

// ===== rtl/core/gelu_tanh_backward_top.sv =====
// GELU backward (tanh approximation) top level: 13-stage fixed-point pipeline.
//
// One request on the in_ channel carries an upstream gradient and the forward
// activation x, both signed 16-bit with FRAC_BITS fraction bits. One request
// leaves on the out_ channel for each one taken in, in order: the gradient
// with respect to x, rounded and saturated to signed 16 bits.
// Throughput: one request per cycle while out_tready is high; no stage
// holds more than one multiplication in series, and tanh uses a ROM of
// TANH_TABLE_DEPTH+1 entries read at two addresses into registers.
// Every stage carries a valid bit and moves when the stage after it is empty
// or moving, so bubbles close up while out_tready is low; in_tready drops
// only when all 13 stages are full. Nothing is lost or repeated under stall.
// Reset (rst_n low, synchronous) clears the valid bits and holds in_tready
// low; the tanh table is constant and needs no fill, so requests are taken
// as soon as rst_n is high.
`timescale 1ns / 1ps

module gelu_tanh_backward_top import gtb_pkg::*; #(
  parameter int FRAC_BITS        = 12,
  parameter int TANH_TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] upstream_grad, [31:16] activation_x
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [15:0] input_grad
);

  localparam int XSH = QB - FRAC_BITS;

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_in;
  logic [NSTG:0]   rdy;

  logic signed [GW-1:0]    g_r    [0:NSTG-2];
  logic signed [XW-1:0]    x_r    [0:NSTG-3];
  logic signed [POLYW-1:0] poly_r [2:8];
  logic signed [CDFW-1:0]  cdf_r  [8:10];

  logic signed [31:0]      x_wide;
  logic signed [XW-1:0]    x0_nxt;
  logic signed [55:0]      prod1;
  logic signed [X2W-1:0]   x2_nxt;
  logic signed [X2W-1:0]   x2_r;
  logic signed [57:0]      prod2a;
  logic signed [52:0]      prod2b;
  logic signed [X3W-1:0]   x3_nxt;
  logic signed [X3W-1:0]   x3_r;
  logic signed [POLYW-1:0] poly_nxt;
  logic signed [52:0]      prod3;
  logic signed [SUMW-1:0]  sum_nxt;
  logic signed [SUMW-1:0]  sum_r;
  logic signed [53:0]      prod4;
  logic signed [UW-1:0]    u_nxt;
  logic signed [UW-1:0]    u_r;
  logic signed [TSW-1:0]   t7;
  logic signed [CDFW-1:0]  cdf_nxt;
  logic signed [51:0]      prod8;
  logic signed [SECHW-1:0] sech2_nxt;
  logic signed [SECHW-1:0] sech2_r;
  logic signed [52:0]      prod9;
  logic signed [P1W-1:0]   p1_nxt;
  logic signed [P1W-1:0]   p1_r;
  logic signed [50:0]      prod10;
  logic signed [P2W-1:0]   p2_nxt;
  logic signed [P2W-1:0]   p2_r;
  logic signed [53:0]      prod11;
  logic signed [DW-1:0]    d_nxt;
  logic signed [DW-1:0]    d_r;
  logic signed [44:0]      prod12;
  logic signed [RESW-1:0]  res_w;
  logic signed [GW-1:0]    res_nxt;
  logic signed [GW-1:0]    res_r;

  gtb_tanh_en_t tanh_en;

  assign rdy[NSTG] = out_tready;
  for (genvar k = 0; k < NSTG; k++) begin : g_rdy
    assign rdy[k] = !vld_r[k] || rdy[k+1];
  end

  assign vld_in     = {vld_r[NSTG-2:0], in_tvalid};
  assign in_tready  = rdy[0] && rst_n;
  assign out_tvalid = vld_r[NSTG-1];
  assign out_tdata  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_in[k];
        end
      end
    end
  end

  always_comb begin
    x_wide = 32'(signed'(in_tdata[31:16])) <<< XSH;
    if (x_wide > 32'(X_LIM)) begin
      x0_nxt = XW'(X_LIM);
    end else if (x_wide < -32'(X_LIM)) begin
      x0_nxt = -XW'(X_LIM);
    end else begin
      x0_nxt = XW'(x_wide);
    end
  end

  always_comb begin
    prod1    = 56'(x_r[0]) * 56'(x_r[0]);
    x2_nxt   = X2W'((prod1 + 56'(ROUND_Q)) >>> QB);
    prod2a   = 58'(x2_r) * 58'(x_r[1]);
    x3_nxt   = X3W'((prod2a + 58'(ROUND_Q)) >>> QB);
    prod2b   = 53'(x2_r) * 53'(K_B);
    poly_nxt = POLYW'(Q_ONE) + POLYW'((prod2b + 53'(ROUND_Q)) >>> QB);
    prod3    = 53'(x3_r) * 53'(K_A);
    sum_nxt  = SUMW'(x_r[2]) + SUMW'((prod3 + 53'(ROUND_Q)) >>> QB);
    prod4    = 54'(sum_r) * 54'(K_SQRT2PI);
    u_nxt    = UW'((prod4 + 54'(ROUND_Q)) >>> QB);
  end

  assign tanh_en = '{st_a: rdy[5], st_b: rdy[6], st_c: rdy[7]};

  gtb_tanh #(
    .TANH_TABLE_DEPTH(TANH_TABLE_DEPTH)
  ) u_tanh (
    .clk(clk),
    .en (tanh_en),
    .u  (u_r),
    .t_r(t7)
  );

  always_comb begin
    cdf_nxt   = CDFW'((27'(t7) + 27'(Q_ONE) + 27'sd1) >>> 1);
    prod8     = 52'(t7) * 52'(t7);
    sech2_nxt = SECHW'(Q_ONE) - SECHW'((prod8 + 52'(ROUND_Q)) >>> QB);
    prod9     = 53'(poly_r[8]) * 53'(sech2_r);
    p1_nxt    = P1W'((prod9 + 53'(ROUND_Q)) >>> QB);
    prod10    = 51'(p1_r) * 51'(K_HALF_SQRT2PI);
    p2_nxt    = P2W'((prod10 + 51'(ROUND_Q)) >>> QB);
    prod11    = 54'(p2_r) * 54'(x_r[10]);
    d_nxt     = DW'(cdf_r[10]) + DW'((prod11 + 54'(ROUND_Q)) >>> QB);
    prod12    = 45'(g_r[11]) * 45'(d_r);
    res_w     = RESW'((prod12 + 45'(ROUND_Q)) >>> QB);
    if (res_w > RESW'(32767)) begin
      res_nxt = 16'sh7fff;
    end else if (res_w < -RESW'(32768)) begin
      res_nxt = -16'sh8000;
    end else begin
      res_nxt = GW'(res_w);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      g_r[0] <= signed'(in_tdata[15:0]);
      x_r[0] <= x0_nxt;
    end
    for (int k = 1; k <= NSTG - 2; k++) begin
      if (rdy[k]) begin
        g_r[k] <= g_r[k-1];
      end
    end
    for (int k = 1; k <= NSTG - 3; k++) begin
      if (rdy[k]) begin
        x_r[k] <= x_r[k-1];
      end
    end
    if (rdy[1]) begin
      x2_r <= x2_nxt;
    end
    if (rdy[2]) begin
      x3_r      <= x3_nxt;
      poly_r[2] <= poly_nxt;
    end
    for (int k = 3; k <= 8; k++) begin
      if (rdy[k]) begin
        poly_r[k] <= poly_r[k-1];
      end
    end
    if (rdy[3]) begin
      sum_r <= sum_nxt;
    end
    if (rdy[4]) begin
      u_r <= u_nxt;
    end
    if (rdy[8]) begin
      cdf_r[8] <= cdf_nxt;
      sech2_r  <= sech2_nxt;
    end
    for (int k = 9; k <= 10; k++) begin
      if (rdy[k]) begin
        cdf_r[k] <= cdf_r[k-1];
      end
    end
    if (rdy[9]) begin
      p1_r <= p1_nxt;
    end
    if (rdy[10]) begin
      p2_r <= p2_nxt;
    end
    if (rdy[11]) begin
      d_r <= d_nxt;
    end
    if (rdy[12]) begin
      res_r <= res_nxt;
    end
  end

`ifndef SYNTHESIS
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&vld_r))
    else $error("input blocked while a stage is empty");

  a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !(out_tvalid && out_tready))
      |=> ($countones(vld_r) == $past($countones(vld_r)) + 1))
    else $error("request lost or duplicated in pipeline");

  a_sech2_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[8] |-> (sech2_r >= 0 && sech2_r <= SECHW'(Q_ONE)))
    else $error("sech2 out of range");

  a_cdf_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[8] |-> (cdf_r[8] >= 0 && cdf_r[8] <= CDFW'(Q_ONE)))
    else $error("cdf term out of range");
`endif

endmodule

// ===== bench/tb_gelu_tanh_backward_top.sv =====
// Self-checking stream testbench for gelu_tanh_backward_top with an in-bench fixed-point predictor.
`timescale 1ns / 1ps

class gelu_grad_board;
  localparam int QB       = 24;
  localparam int FRAC     = 12;
  localparam int DEPTH    = 256;
  localparam longint ONE  = longint'(1) <<< QB;
  localparam longint XLIM = longint'(4) <<< QB;
  localparam longint KS   = 13386282;
  localparam longint KH   = 6693141;
  localparam longint KA   = 750193;
  localparam longint KB   = 2250580;

  typedef struct {
    logic [15:0] grad;
    logic [15:0] act;
    logic [15:0] want;
  } grad_req_t;

  grad_req_t pending[$];
  longint unsigned tanh_rom[DEPTH+1];
  int errors;

  function new();
    longint unsigned z, e, num, den, pos, neg, term;
    errors = 0;
    for (longint unsigned k = 0; k <= DEPTH; k++) begin
      z = ((k << 30) + DEPTH / 2) / DEPTH;
      pos = 64'd1 << 31;
      neg = 0;
      term = 64'd1 << 31;
      for (longint unsigned n = 1; n <= 20; n++) begin
        term = ((term * z + (64'd1 << 30)) >> 31) / n;
        if (n[0]) begin
          neg = neg + term;
        end else begin
          pos = pos + term;
        end
      end
      e = pos - neg;
      for (int s = 0; s < 4; s++) begin
        e = (e * e + (64'd1 << 30)) >> 31;
      end
      num = ((64'd1 << 31) - e) << QB;
      den = (64'd1 << 31) + e;
      tanh_rom[k] = (num + den / 2) / den;
    end
  endfunction

  function longint round_up(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function longint tanh_fix(longint u);
    longint a, t;
    longint unsigned p, i, r, lo, hi;
    a = (u < 0) ? -u : u;
    if (a >= XLIM) begin
      t = ONE;
    end else begin
      p = longint'(a) * DEPTH;
      i = p >> 26;
      r = p & ((64'd1 << 26) - 1);
      if (i >= DEPTH) i = DEPTH - 1;
      lo = tanh_rom[i];
      hi = tanh_rom[i+1];
      if (hi < lo) hi = lo;
      t = longint'(lo + (((hi - lo) * r + (64'd1 << 25)) >> 26));
    end
    return (u < 0) ? -t : t;
  endfunction

  function logic [15:0] grad_of(logic [15:0] g16, logic [15:0] x16);
    longint g, x, x2, x3, u, t, cdf, sech2, poly, p, d, res;
    g = longint'($signed(g16));
    x = longint'($signed(x16)) <<< (QB - FRAC);
    if (x > XLIM) x = XLIM;
    if (x < -XLIM) x = -XLIM;
    x2 = round_up(x * x, QB);
    x3 = round_up(x2 * x, QB);
    u = round_up(KS * (x + round_up(KA * x3, QB)), QB);
    t = tanh_fix(u);
    cdf = round_up(ONE + t, 1);
    sech2 = ONE - round_up(t * t, QB);
    poly = ONE + round_up(KB * x2, QB);
    p = round_up(poly * sech2, QB);
    p = round_up(p * KH, QB);
    p = round_up(p * x, QB);
    d = cdf + p;
    res = round_up(g * d, QB);
    if (res > 32767) res = 32767;
    if (res < -32768) res = -32768;
    return res[15:0];
  endfunction

  function void note_request(logic [15:0] g, logic [15:0] x);
    grad_req_t req;
    req.grad = g;
    req.act = x;
    req.want = grad_of(g, x);
    pending.push_back(req);
  endfunction

  function void check_result(logic [15:0] got);
    grad_req_t req;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result input_grad=%0d", $signed(got));
    end else begin
      req = pending.pop_front();
      if (got !== req.want) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch grad=%0d x=%0d: input_grad expected %0d got %0d",
                   $signed(req.grad), $signed(req.act), $signed(req.want), $signed(got));
        end
      end
    end
  endfunction
endclass

module tb_gelu_tanh_backward_top;
  localparam int QUIET_LIMIT = 5000;
  localparam int N_DIRECTED  = 24;
  localparam int N_PER_PHASE = 257;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  int idle_pct  = 0;
  int stall_pct = 0;
  int quiet     = 0;
  gelu_grad_board board;

  int dir_g [N_DIRECTED] = '{32767, -32768, 4096, 4096, 4096, 4096, 4096, 4096,
                             4096, 32767, -32768, 32767, -32768, 32767, -32768, 1,
                             -1, 0, 4096, 4096, 4096, -4096, 16384, 32767};
  int dir_x [N_DIRECTED] = '{0, 0, 0, 32767, -32768, 16384, -16384, 16385,
                             -16385, 16384, 16384, -32768, -32768, 4096, 4096, 1,
                             -1, 12345, -4096, -6144, 8192, 2048, -1, 32767};

  gelu_tanh_backward_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic send_request(input logic [15:0] g, input logic [15:0] x);
    if ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {x, g};
    do @(posedge clk); while (!in_tready);
    board.note_request(g, x);
  endtask

  task automatic send_random;
    logic [15:0] g, x;
    int pick;
    pick = $urandom_range(99);
    g = (pick < 70) ? 16'($urandom) : 16'($urandom_range(8192) - 4096);
    pick = $urandom_range(99);
    if (pick < 60) begin
      x = 16'($urandom_range(40000) - 20000);
    end else if (pick < 80) begin
      x = 16'($urandom);
    end else begin
      x = 16'($urandom_range(8192) - 4096);
    end
    send_request(g, x);
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet = 0;
    end else begin
      quiet = quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    board = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < N_DIRECTED; i++) send_request(16'(dir_g[i]), 16'(dir_x[i]));
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 50; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 50; end
        default: begin idle_pct = 24; stall_pct = 24; end
      endcase
      for (int i = 0; i < N_PER_PHASE; i++) send_random();
    end
    in_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== gelu_tanh_backward_top.f =====
rtl/core/gtb_pkg.sv
rtl/core/gtb_tanh.sv
rtl/core/gelu_tanh_backward_top.sv
bench/tb_gelu_tanh_backward_top.sv
